// ----- hdl/jukes_cantor_mismatch_distance_defines.svh -----
// Assertion macros for the mismatch distance block.
// Used by the checker only; needs clk and rst_n in scope.
`ifndef JUKES_CANTOR_MISMATCH_DISTANCE_DEFINES_SVH
`define JUKES_CANTOR_MISMATCH_DISTANCE_DEFINES_SVH

// checked outside reset
`define JCMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked through reset as well
`define JCMD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/jcmd_pkg.sv -----
// Shared types and constants of the mismatch distance block.
// No dependencies.
package jcmd_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int STEP_W     = 5;
    localparam int MANT_W     = 31;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int KJC_W      = 30;
    localparam int ACC_W      = 67;
    localparam int ROUND_BIT  = 33;
    localparam int Q_LSB      = 34;
    localparam int WORD_W     = 32;

    // round(0.75 * ln 2 * 2^30)
    localparam logic [KJC_W-1:0] K_JC = 30'd558195838;
    localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << ROUND_BIT;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_SQUARE,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_ROUND,
        ST_DONE
    } jcmd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic saturated;
        logic invalid;
    } jcmd_stat_t;

endpackage

// ----- hdl/jcmd_core.sv -----
// Distance sequencer: one-bit normalising shifter and shared 32x32 multiplier
// computing log2 of 3n and 3n-4c, their difference and the scaled distance.
// Depends on jcmd_pkg.
module jcmd_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COUNT_WIDTH-1:0]  count_in,
    input  logic [COUNT_WIDTH-1:0]  length_in,
    input  logic                    take,
    output jcmd_pkg::jcmd_stat_t    stat,
    output logic [31:0]             distance,
    output logic [31:0]             count_out,
    output logic [31:0]             length_out
);
    import jcmd_pkg::*;

    localparam int VW   = COUNT_WIDTH + 2;
    localparam int NW   = (VW > MANT_W) ? VW : MANT_W;
    localparam int EW   = $clog2(NW);
    localparam int LW   = EW + FRAC_BITS;
    localparam int HALF = (LW + 1) / 2;
    localparam int DW   = 2 * HALF;
    localparam int QW   = ACC_W - Q_LSB;

    jcmd_state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0] cnt_c_reg, cnt_n_reg;
    logic [NW-1:0]          norm_reg;
    logic [EW-1:0]          exp_reg;
    logic [MANT_W-1:0]      mant_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   second_reg;
    logic [LW-1:0]          ld_reg, lm_reg;
    logic [DW-1:0]          diff_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [31:0]            dist_reg;
    logic                   sat_reg, inval_reg;

    logic [VW-1:0]          d3, c4, m_val;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [MUL_W-1:0]       sq_sh;
    logic                   sq_bit;
    logic [MANT_W-1:0]      mant_new;
    logic [FRAC_BITS-1:0]   frac_new;
    logic [LW-1:0]          log_new;
    logic                   last_step;
    logic [QW-1:0]          q;

    assign d3 = {1'b0, cnt_n_reg, 1'b0} + {2'b00, cnt_n_reg};
    assign c4 = {cnt_c_reg, 2'b00};
    assign m_val = d3 - c4;

    always_comb
    begin
        case (state_reg)
            ST_SQUARE:
            begin
                mul_a = {1'b0, mant_reg};
                mul_b = {1'b0, mant_reg};
            end
            ST_MUL_LO:
            begin
                mul_a = MUL_W'(diff_reg[HALF-1:0]);
                mul_b = MUL_W'(K_JC);
            end
            ST_MUL_HI:
            begin
                mul_a = MUL_W'(diff_reg[DW-1:HALF]);
                mul_b = MUL_W'(K_JC);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign sq_sh     = mul_p[MANT_W+MANT_W-1:MANT_W-1];
    assign sq_bit    = sq_sh[MUL_W-1];
    assign mant_new  = sq_bit ? sq_sh[MUL_W-1:1] : sq_sh[MANT_W-1:0];
    assign frac_new  = {frac_reg[FRAC_BITS-2:0], sq_bit};
    assign log_new   = {exp_reg, frac_new};
    assign last_step = (step_reg == STEP_W'(FRAC_BITS - 1));
    assign q         = acc_reg[ACC_W-1:Q_LSB];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if ((c4 >= d3) || (cnt_c_reg == '0))
                    state_next = ST_DONE;
                else
                    state_next = ST_NORM;
            end
            ST_NORM:   if (norm_reg[NW-1]) state_next = ST_SQUARE;
            ST_SQUARE:
            begin
                if (last_step)
                    state_next = second_reg ? ST_DIFF : ST_NORM;
            end
            ST_DIFF:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_DONE;
            ST_DONE:   if (take) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy      = (state_reg != ST_IDLE);
        stat.done      = (state_reg == ST_DONE);
        stat.saturated = sat_reg;
        stat.invalid   = inval_reg;
    end

    assign distance   = dist_reg;
    assign count_out  = WORD_W'(cnt_c_reg);
    assign length_out = WORD_W'(cnt_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CHECK)
            begin
                step_reg   <= '0;
                second_reg <= 1'b0;
            end
            else if (state_reg == ST_SQUARE)
            begin
                if (last_step)
                begin
                    step_reg   <= '0;
                    second_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_c_reg <= count_in;
                    cnt_n_reg <= length_in;
                end
            end
            ST_CHECK:
            begin
                norm_reg  <= NW'(d3);
                exp_reg   <= EW'(NW - 1);
                inval_reg <= (c4 >= d3);
                sat_reg   <= 1'b0;
                dist_reg  <= '0;
            end
            ST_NORM:
            begin
                if (norm_reg[NW-1])
                begin
                    mant_reg <= norm_reg[NW-1 -: MANT_W];
                end
                else
                begin
                    norm_reg <= {norm_reg[NW-2:0], 1'b0};
                    exp_reg  <= exp_reg - EW'(1);
                end
            end
            ST_SQUARE:
            begin
                mant_reg <= mant_new;
                frac_reg <= frac_new;
                if (last_step)
                begin
                    if (second_reg)
                    begin
                        lm_reg <= log_new;
                    end
                    else
                    begin
                        ld_reg   <= log_new;
                        norm_reg <= NW'(m_val);
                        exp_reg  <= EW'(NW - 1);
                    end
                end
            end
            ST_DIFF:
            begin
                diff_reg <= (ld_reg > lm_reg) ? DW'(ld_reg - lm_reg) : '0;
            end
            ST_MUL_LO:
            begin
                prod_reg <= mul_p;
            end
            ST_MUL_HI:
            begin
                acc_reg  <= ACC_W'(prod_reg) + ROUND_ADD;
                prod_reg <= mul_p;
            end
            ST_ACC:
            begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) << HALF);
            end
            ST_ROUND:
            begin
                sat_reg  <= |q[QW-1:WORD_W];
                dist_reg <= (|q[QW-1:WORD_W]) ? '1 : q[WORD_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/jukes_cantor_mismatch_distance.sv -----
// Pair counters, result register and distance sequencer; depends on jcmd_pkg, jcmd_core.
// One pair per cycle within a sequence. After the last pair the input stalls for
// the sequencer's run (and longer while the output register is held): one-bit
// normalising shifts plus one multiplier pass per fraction bit, for two logarithms.
// The result then waits in an output register; counting of the next sequence may
// go on. Reset clears the counters, the sequencer and the result valid flag.
module jukes_cantor_mismatch_distance #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  base_a,
    input  logic [7:0]  base_b,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] mismatch_count,
    output logic [31:0] sequence_length,
    output logic [31:0] distance,
    output logic        saturated,
    output logic        invalid
);
    import jcmd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] len_cnt_reg, mis_cnt_reg;
    logic [COUNT_WIDTH-1:0] len_fin, mis_fin;
    logic                   accept, start, take, load;
    jcmd_stat_t             stat;
    logic [31:0]            core_dist, core_count, core_length;

    logic        result_valid_reg;
    logic [31:0] mis_out_reg, len_out_reg, dist_out_reg;
    logic        sat_out_reg, inval_out_reg;

    assign accept  = item_valid && !item_stall;
    assign start   = accept && last;
    assign len_fin = (len_cnt_reg == CNT_MAX) ? len_cnt_reg : len_cnt_reg + COUNT_WIDTH'(1);
    assign mis_fin = ((base_a != base_b) && (mis_cnt_reg != CNT_MAX)) ?
                     mis_cnt_reg + COUNT_WIDTH'(1) : mis_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cnt_reg <= '0;
            mis_cnt_reg <= '0;
        end
        else if (accept)
        begin
            len_cnt_reg <= last ? '0 : len_fin;
            mis_cnt_reg <= last ? '0 : mis_fin;
        end
    end

    jcmd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .count_in   (mis_fin),
        .length_in  (len_fin),
        .take       (take),
        .stat       (stat),
        .distance   (core_dist),
        .count_out  (core_count),
        .length_out (core_length)
    );

    assign item_stall = stat.busy;
    assign take       = !result_valid_reg || !result_stall;
    assign load       = stat.done && take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (take)
            result_valid_reg <= stat.done;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mis_out_reg   <= core_count;
            len_out_reg   <= core_length;
            dist_out_reg  <= core_dist;
            sat_out_reg   <= stat.saturated;
            inval_out_reg <= stat.invalid;
        end
    end

    assign result_valid    = result_valid_reg;
    assign mismatch_count  = mis_out_reg;
    assign sequence_length = len_out_reg;
    assign distance        = dist_out_reg;
    assign saturated       = sat_out_reg;
    assign invalid         = inval_out_reg;

endmodule

// ----- hdl/jcmd_chk.sv -----
// Port-level checks of the mismatch distance block, bound to the top level.
// Depends on jukes_cantor_mismatch_distance_defines.svh.
`include "jukes_cantor_mismatch_distance_defines.svh"

module jcmd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        last,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] distance,
    input logic        saturated,
    input logic        invalid
);

    `JCMD_ASSERT(a_invalid_zero, result_valid && invalid |-> distance == 32'd0 && !saturated, "invalid word carries a distance")
    `JCMD_ASSERT(a_sat_max, result_valid && saturated |-> distance == 32'hFFFF_FFFF, "saturated word not clamped")
    `JCMD_ASSERT(a_last_stalls, item_valid && !item_stall && last |=> item_stall, "input not held after final pair")
    `JCMD_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "stalled result word dropped")
    `JCMD_ASSERT_RST(a_reset_quiet, !rst_n |=> !result_valid, "result word shown out of reset")

endmodule

bind jukes_cantor_mismatch_distance jcmd_chk u_chk (.*);

// ----- tb/tb_jukes_cantor_mismatch_distance.sv -----
// Self-checking testbench for jukes_cantor_mismatch_distance: streams byte pair sequences and
// checks count, length, Q8.24 distance and flags against a fixed-point predictor.
// Depends on hdl/jcmd_pkg.sv and hdl/jukes_cantor_mismatch_distance.sv.
module tb_jukes_cantor_mismatch_distance;

    import jcmd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned PHASE_WORDS = 360;
    localparam int unsigned SETTLE      = 200;
    localparam logic [63:0] MANT_TWO_Q  = 64'h8000_0000;
    localparam logic [31:0] CNT_TOP     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] len;
        logic [31:0] dval;
        logic        sat;
        logic        inv;
    } jc_result_t;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic        l;
        logic        typed;
        jc_result_t  exp;
    } pair_row_t;

    localparam int DIR_ROWS = 19;
    localparam pair_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 8'h00, 1'b1, 1'b1, '{32'd0, 32'd1, 32'd0, 1'b0, 1'b0}},
        '{8'hFF, 8'h00, 1'b1, 1'b1, '{32'd1, 32'd1, 32'd0, 1'b0, 1'b1}},
        '{8'h00, 8'hFF, 1'b1, 1'b1, '{32'd1, 32'd1, 32'd0, 1'b0, 1'b1}},
        '{8'hFF, 8'hFF, 1'b1, 1'b1, '{32'd0, 32'd1, 32'd0, 1'b0, 1'b0}},
        '{8'h01, 8'h02, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h03, 8'h03, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'hAA, 8'h55, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h80, 8'h7F, 1'b1, 1'b1, '{32'd3, 32'd4, 32'd0, 1'b0, 1'b1}},
        '{8'h01, 8'h00, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h02, 8'h02, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h00, 8'h01, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h05, 8'h05, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h06, 8'h06, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h07, 8'h07, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'hFF, 8'hFE, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h0F, 8'h0F, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'hF0, 8'hF0, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'h55, 8'h55, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
        '{8'hAA, 8'hAA, 1'b1, 1'b1, '{32'd0, 32'd4, 32'd0, 1'b0, 1'b0}}
    };

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [7:0]  base_a;
    logic [7:0]  base_b;
    logic        last;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] mismatch_count;
    logic [31:0] sequence_length;
    logic [31:0] distance;
    logic        saturated;
    logic        invalid;

    jc_result_t   pending_results [$];
    logic [31:0]  mm_cnt;
    logic [31:0]  len_cnt;
    int unsigned  fault_count;
    int unsigned  cycle_count;
    int unsigned  idle_pct;
    int unsigned  stall_pct;
    int unsigned  words_sent;

    jukes_cantor_mismatch_distance #(
        .COUNT_WIDTH(32)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .base_a         (base_a),
        .base_b         (base_b),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .mismatch_count (mismatch_count),
        .sequence_length(sequence_length),
        .distance       (distance),
        .saturated      (saturated),
        .invalid        (invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // log2 with 28 fraction bits, mantissa squared in Q1.30
    function automatic logic [63:0] log2_q28(input logic [63:0] v);
        int unsigned e;
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        t = v;
        frac = '0;
        if (v == 0)
            return '0;
        while (t > 1)
        begin
            t = t >> 1;
            e++;
        end
        if (e > 30)
            m = v >> (e - 30);
        else
            m = v << (30 - e);
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            m = (m * m) >> 30;
            if (m >= MANT_TWO_Q)
            begin
                m = m >> 1;
                frac[FRAC_BITS-1-i] = 1'b1;
            end
        end
        return (64'(e) << FRAC_BITS) | frac;
    endfunction

    function automatic bit jc_distance_step(input logic [7:0] a, input logic [7:0] b,
                                            input logic l, output jc_result_t r);
        logic [63:0] d3;
        logic [63:0] c4;
        logic [63:0] ld;
        logic [63:0] lm;
        logic [63:0] diff;
        logic [63:0] q;
        r = '0;
        if (len_cnt != CNT_TOP)
            len_cnt++;
        if (a != b && mm_cnt != CNT_TOP)
            mm_cnt++;
        if (!l)
            return 1'b0;
        d3 = 64'(len_cnt) * 3;
        c4 = 64'(mm_cnt) * 4;
        r.count = mm_cnt;
        r.len = len_cnt;
        if (c4 >= d3)
            r.inv = 1'b1;
        else if (mm_cnt != 0)
        begin
            ld = log2_q28(d3);
            lm = log2_q28(d3 - c4);
            diff = (ld > lm) ? ld - lm : 64'd0;
            q = (diff * 64'(K_JC) + (64'd1 << ROUND_BIT)) >> Q_LSB;
            if (q > 64'(CNT_TOP))
            begin
                r.dval = CNT_TOP;
                r.sat = 1'b1;
            end
            else
                r.dval = q[31:0];
        end
        mm_cnt = '0;
        len_cnt = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
        fault_count++;
    endtask

    // one word through the input handshake
    task automatic push_pair(input logic [7:0] a, input logic [7:0] b, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        base_a <= a;
        base_b <= b;
        last <= l;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic l);
        jc_result_t r;
        push_pair(a, b, l);
        if (jc_distance_step(a, b, l, r))
            pending_results.push_back(r);
        words_sent++;
    endtask

    // exactly k mismatches spread at random over n pairs
    task automatic send_sequence(input int unsigned n, input int unsigned k);
        int unsigned need;
        logic [7:0] a;
        logic [7:0] b;
        bit mis;
        need = k;
        for (int unsigned i = 0; i < n; i++)
        begin
            mis = need != 0 && $urandom_range(n - i - 1) < need;
            if (mis)
                need--;
            a = 8'($urandom_range(255));
            b = mis ? a ^ 8'($urandom_range(1, 255)) : a;
            send_pair(a, b, i == n - 1);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        jc_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected word, count", mismatch_count, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (mismatch_count !== want.count)
                    flag_mismatch("mismatch_count", mismatch_count, want.count);
                if (sequence_length !== want.len)
                    flag_mismatch("sequence_length", sequence_length, want.len);
                if (distance !== want.dval)
                    flag_mismatch("distance", distance, want.dval);
                if (saturated !== want.sat)
                    flag_mismatch("saturated", 32'(saturated), 32'(want.sat));
                if (invalid !== want.inv)
                    flag_mismatch("invalid", 32'(invalid), 32'(want.inv));
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("jukes_cantor_mismatch_distance verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned k;
        int unsigned sel;
        int unsigned idle_set [5];
        int unsigned stall_set [5];
        jc_result_t r;
        idle_set = '{0, 84, 0, 33, 0};
        stall_set = '{0, 0, 84, 33, 0};
        cycle_count = 0;
        fault_count = 0;
        words_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        mm_cnt = '0;
        len_cnt = '0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        base_a = '0;
        base_b = '0;
        last = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            push_pair(DIR_TAB[i].a, DIR_TAB[i].b, DIR_TAB[i].l);
            if (jc_distance_step(DIR_TAB[i].a, DIR_TAB[i].b, DIR_TAB[i].l, r))
                pending_results.push_back(DIR_TAB[i].typed ? DIR_TAB[i].exp : r);
        end
        // hold off until the directed results are all back
        drain_results();

        for (int p = 0; p < 5; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            words_sent = 0;
            while (words_sent < PHASE_WORDS)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    n = $urandom_range(1, 8);
                else if (sel < 95)
                    n = $urandom_range(9, 60);
                else
                    n = $urandom_range(61, 400);
                case ($urandom_range(5))
                    0: k = $urandom_range(0, n);
                    1: k = 0;
                    2: k = n;
                    3: k = (3 * n + 3) / 4;
                    4: k = (3 * n - 1) / 4;
                    default: k = $urandom_range(0, (3 * n - 1) / 4);
                endcase
                send_sequence(n, k);
            end
            drain_results();
        end

        stall_pct = 0;
        repeat (SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch("results left over", pending_results.size(), 32'd0);
        if (fault_count == 0)
            $display("jukes_cantor_mismatch_distance verification clean");
        else
            $display("jukes_cantor_mismatch_distance verification failed");
        $finish;
    end

endmodule
